// File: rtl/scc_pkg.sv
// Shared widths, constants and pipeline side-band types for the swept circle collision block.
package scc_pkg;

  // Input coordinate width and fractional bits of the impact time.
  localparam int COORD_W = 32;
  localparam int TFB     = 16;

  // Output normal: Q2.14, one search stage per magnitude bit.
  localparam int NRM_FRAC = 14;
  localparam int NRM_W    = 16;
  localparam int NS       = NRM_FRAC + 1;

  // Relative start position, dot products and the quadratic's coefficients.
  localparam int U_W = COORD_W + 2;
  localparam int A_W = 2 * COORD_W;
  localparam int H_W = 2 * COORD_W + 3;
  localparam int C_W = 2 * COORD_W + 5;
  localparam int O_W = C_W + 1;

  // Time search: scaled quadratic value and the running a*t product.
  localparam int G_W = C_W + 2 * TFB + 3;
  localparam int P_W = A_W + TFB + 1;

  // Impact vector, its magnitude and squared length.
  localparam int T_W   = COORD_W + TFB + 1;
  localparam int N_W   = U_W + TFB + 1;
  localparam int M_W   = N_W - 1;
  localparam int LO_W  = M_W / 2;
  localparam int HI_W  = M_W - LO_W;
  localparam int SQ_W  = 2 * M_W;
  localparam int N2_W  = SQ_W + 1;

  // Normal search: residual and the running m*n2 product.
  localparam int Q_W = N2_W + NRM_FRAC + 1;
  localparam int E_W = Q_W + NRM_FRAC + 4;

  typedef struct packed {
    logic                       valid;
    logic                       ovl;
    logic                       sin;
    logic                       appr;
    logic signed [U_W-1:0]      ux;
    logic signed [U_W-1:0]      uy;
    logic signed [COORD_W-1:0]  vx;
    logic signed [COORD_W-1:0]  vy;
  } toi_side_t;

  typedef struct packed {
    logic           valid;
    logic           ovl;
    logic           hit;
    logic [TFB-1:0] teff;
    logic           sx;
    logic           sy;
    logic           n2z;
  } nrm_side_t;

endpackage

// File: rtl/scc_toi.sv
// Pipelined bit-by-bit search for the time of impact, one time bit per stage.
module scc_toi import scc_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [A_W-1:0]         a,
  input  logic signed [H_W-1:0]  h,
  input  logic signed [C_W-1:0]  c,
  output logic [TFB-1:0]         t
);

  logic [G_W-1:0]        g_r [TFB];
  logic [P_W-1:0]        p_r [TFB];
  logic [TFB-1:0]        t_r [TFB];
  logic [A_W-1:0]        a_r [TFB];
  logic signed [H_W-1:0] h_r [TFB];

  // Each stage keeps g = a t^2 + 2 h t 2^F + c 4^F and p = a t for the
  // current t, so a trial bit needs only shifts and adds, no multiplier.
  for (genvar k = 0; k < TFB; k++) begin : g_stage
    localparam int B = TFB - 1 - k;
    logic [G_W-1:0]        g_i;
    logic [G_W-1:0]        g_c;
    logic [P_W-1:0]        p_i;
    logic [TFB-1:0]        t_i;
    logic [A_W-1:0]        a_i;
    logic signed [H_W-1:0] h_i;
    logic                  ok;

    if (k == 0) begin : g_first
      assign g_i = G_W'(c) << (2 * TFB);
      assign p_i = '0;
      assign t_i = '0;
      assign a_i = a;
      assign h_i = h;
    end else begin : g_rest
      assign g_i = g_r[k-1];
      assign p_i = p_r[k-1];
      assign t_i = t_r[k-1];
      assign a_i = a_r[k-1];
      assign h_i = h_r[k-1];
    end

    assign g_c = g_i + (G_W'(p_i) << (B + 1)) + (G_W'(a_i) << (2 * B))
                 + (G_W'(h_i) << (TFB + 1 + B));
    assign ok  = !g_c[G_W-1];

    always_ff @(posedge clk) begin
      if (en) begin
        g_r[k] <= ok ? g_c : g_i;
        p_r[k] <= ok ? (p_i + (P_W'(a_i) << B)) : p_i;
        t_r[k] <= ok ? (t_i | (TFB'(1) << B)) : t_i;
        a_r[k] <= a_i;
        h_r[k] <= h_i;
      end
    end
  end

  assign t = t_r[TFB-1];

endmodule

// File: rtl/scc_norm.sv
// Pipelined search for one normal component magnitude, one bit per stage.
module scc_norm import scc_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [N2_W-1:0]   n2,
  input  logic [SQ_W-1:0]   sq,
  output logic [NS-1:0]     m
);

  logic [E_W-1:0]  e_r  [NS];
  logic [Q_W-1:0]  q_r  [NS];
  logic [NS-1:0]   m_r  [NS];
  logic [N2_W-1:0] n2_r [NS];

  // The residual e = comp^2 2^28 - m^2 n2 and q = m n2 are kept per stage.
  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int B = NS - 1 - k;
    logic [E_W-1:0]  e_i;
    logic [E_W-1:0]  e_c;
    logic [Q_W-1:0]  q_i;
    logic [NS-1:0]   m_i;
    logic [N2_W-1:0] n2_i;
    logic            ok;

    if (k == 0) begin : g_first
      assign e_i  = E_W'(sq) << (2 * NRM_FRAC);
      assign q_i  = '0;
      assign m_i  = '0;
      assign n2_i = n2;
    end else begin : g_rest
      assign e_i  = e_r[k-1];
      assign q_i  = q_r[k-1];
      assign m_i  = m_r[k-1];
      assign n2_i = n2_r[k-1];
    end

    assign e_c = e_i - (E_W'(q_i) << (B + 1)) - (E_W'(n2_i) << (2 * B));
    assign ok  = !e_c[E_W-1];

    always_ff @(posedge clk) begin
      if (en) begin
        e_r[k]  <= ok ? e_c : e_i;
        q_r[k]  <= ok ? (q_i + (Q_W'(n2_i) << B)) : q_i;
        m_r[k]  <= ok ? (m_i | (NS'(1) << B)) : m_i;
        n2_r[k] <= n2_i;
      end
    end
  end

  assign m = m_r[NS-1];

endmodule

// File: rtl/swept_circle_collision.sv
// Top level of the swept circle collision block: overlap, time of impact and normal.
// Throughput is one item per cycle while out_stall does not hold the output register;
// the time and normal searches each retire one bit per pipeline stage, so the depth is
// set by 16 time bits and 15 normal bits.
// Reset clears every valid bit in the pipeline and the output register; payload
// registers are not reset. The whole pipeline advances whenever the output
// register is empty or its item is being taken.
module swept_circle_collision import scc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [COORD_W-1:0]  self_pos_x,
  input  logic signed [COORD_W-1:0]  self_pos_y,
  input  logic signed [COORD_W-1:0]  vel_x,
  input  logic signed [COORD_W-1:0]  vel_y,
  input  logic [COORD_W-2:0]         self_radius,
  input  logic signed [COORD_W-1:0]  other_pos_x,
  input  logic signed [COORD_W-1:0]  other_pos_y,
  input  logic [COORD_W-2:0]         other_radius,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       overlapping,
  output logic                       hit,
  output logic [TFB-1:0]             impact_time,
  output logic signed [NRM_W-1:0]    normal_x,
  output logic signed [NRM_W-1:0]    normal_y
);

  logic en;

  // Every stage moves together; the output register is the last stage.
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 1: start position relative to the other centre, and the radius sum.
  logic                      v1;
  logic signed [U_W-1:0]     ux1, uy1;
  logic signed [COORD_W-1:0] vx1, vy1;
  logic [COORD_W-1:0]        rs1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux1 <= U_W'(self_pos_x) - U_W'(other_pos_x) - U_W'(vel_x);
      uy1 <= U_W'(self_pos_y) - U_W'(other_pos_y) - U_W'(vel_y);
      vx1 <= vel_x;
      vy1 <= vel_y;
      rs1 <= COORD_W'(self_radius) + COORD_W'(other_radius);
    end
  end

  // Stage 2: the seven products that make up the quadratic's coefficients.
  logic                      v2;
  logic signed [A_W-1:0]     pvv_x2, pvv_y2;
  logic signed [H_W-1:0]     puv_x2, puv_y2;
  logic signed [C_W-1:0]     puu_x2, puu_y2;
  logic [A_W-1:0]            prr2;
  logic signed [U_W-1:0]     ux2, uy2;
  logic signed [COORD_W-1:0] vx2, vy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pvv_x2 <= A_W'(vx1) * A_W'(vx1);
      pvv_y2 <= A_W'(vy1) * A_W'(vy1);
      puv_x2 <= H_W'(ux1) * H_W'(vx1);
      puv_y2 <= H_W'(uy1) * H_W'(vy1);
      puu_x2 <= C_W'(ux1) * C_W'(ux1);
      puu_y2 <= C_W'(uy1) * C_W'(uy1);
      prr2   <= A_W'(rs1) * A_W'(rs1);
      ux2    <= ux1;
      uy2    <= uy1;
      vx2    <= vx1;
      vy2    <= vy1;
    end
  end

  // Stage 3: a = v.v, h = u.v and c = u.u - R^2 for |u + v t|^2 = R^2.
  logic                      v3;
  logic [A_W-1:0]            a3;
  logic signed [H_W-1:0]     h3;
  logic signed [C_W-1:0]     c3;
  logic signed [U_W-1:0]     ux3, uy3;
  logic signed [COORD_W-1:0] vx3, vy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3  <= A_W'(pvv_x2) + A_W'(pvv_y2);
      h3  <= puv_x2 + puv_y2;
      c3  <= puu_x2 + puu_y2 - C_W'(prr2);
      ux3 <= ux2;
      uy3 <= uy2;
      vx3 <= vx2;
      vy3 <= vy2;
    end
  end

  // The end-position distance test is the quadratic at t = 1: a + 2h + c < 0.
  // When that holds and the start is outside (c >= 0) the quadratic changes
  // sign inside the step, so a root in [0,1) always exists and the search
  // below always finds a hit.
  logic [O_W-1:0] f1;
  toi_side_t      sd1_in;
  toi_side_t      sd1 [TFB];

  assign f1 = O_W'(a3) + (O_W'(h3) << 1) + O_W'(c3);

  always_comb begin
    sd1_in.valid = v3;
    sd1_in.ovl   = f1[O_W-1];
    sd1_in.sin   = c3[C_W-1];
    sd1_in.appr  = h3[H_W-1];
    sd1_in.ux    = ux3;
    sd1_in.uy    = uy3;
    sd1_in.vx    = vx3;
    sd1_in.vy    = vy3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TFB; i++) begin
        sd1[i].valid <= 1'b0;
      end
    end else if (en) begin
      sd1[0] <= sd1_in;
      for (int i = 1; i < TFB; i++) begin
        sd1[i] <= sd1[i-1];
      end
    end
  end

  logic [TFB-1:0] t_s;

  scc_toi u_toi (
    .clk (clk),
    .en  (en),
    .a   (a3),
    .h   (h3),
    .c   (c3),
    .t   (t_s)
  );

  // Stage 5: settle hit and time, then scale the velocity by the time.
  // A start already inside the other circle reports time zero while approaching.
  logic                  v5, ovl5, hit5;
  logic [TFB-1:0]        teff5;
  logic signed [U_W-1:0] ux5, uy5;
  logic signed [T_W-1:0] pvt_x5, pvt_y5;
  logic [TFB-1:0]        teff;
  logic                  hit_c;

  assign teff  = sd1[TFB-1].sin ? '0 : t_s;
  assign hit_c = sd1[TFB-1].ovl && (!sd1[TFB-1].sin || sd1[TFB-1].appr);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= sd1[TFB-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovl5   <= sd1[TFB-1].ovl;
      hit5   <= hit_c;
      teff5  <= teff;
      ux5    <= sd1[TFB-1].ux;
      uy5    <= sd1[TFB-1].uy;
      pvt_x5 <= T_W'(sd1[TFB-1].vx) * T_W'(teff);
      pvt_y5 <= T_W'(sd1[TFB-1].vy) * T_W'(teff);
    end
  end

  // Stage 6: the impact vector u 2^F + v t, from the other centre.
  logic                  v6, ovl6, hit6;
  logic [TFB-1:0]        teff6;
  logic signed [N_W-1:0] nx6, ny6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovl6  <= ovl5;
      hit6  <= hit5;
      teff6 <= teff5;
      nx6   <= (N_W'(ux5) << TFB) + N_W'(pvt_x5);
      ny6   <= (N_W'(uy5) << TFB) + N_W'(pvt_y5);
    end
  end

  // Stage 7: magnitudes and signs; a zero vector gives a zero normal.
  logic             v7, ovl7, hit7, sx7, sy7, n2z7;
  logic [TFB-1:0]   teff7;
  logic [M_W-1:0]   mx7, my7;
  logic [N_W-1:0]   absx, absy;

  assign absx = nx6[N_W-1] ? (-nx6) : nx6;
  assign absy = ny6[N_W-1] ? (-ny6) : ny6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovl7  <= ovl6;
      hit7  <= hit6;
      teff7 <= teff6;
      sx7   <= nx6[N_W-1];
      sy7   <= ny6[N_W-1];
      n2z7  <= (nx6 == '0) && (ny6 == '0);
      mx7   <= absx[M_W-1:0];
      my7   <= absy[M_W-1:0];
    end
  end

  // Stage 8: the squares are built from half-width partial products.
  logic                   v8, ovl8, hit8, sx8, sy8, n2z8;
  logic [TFB-1:0]         teff8;
  logic [2*HI_W-1:0]      hh_x8, hh_y8;
  logic [HI_W+LO_W-1:0]   hl_x8, hl_y8;
  logic [2*LO_W-1:0]      ll_x8, ll_y8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovl8  <= ovl7;
      hit8  <= hit7;
      teff8 <= teff7;
      sx8   <= sx7;
      sy8   <= sy7;
      n2z8  <= n2z7;
      hh_x8 <= (2*HI_W)'(mx7[M_W-1:LO_W]) * (2*HI_W)'(mx7[M_W-1:LO_W]);
      hh_y8 <= (2*HI_W)'(my7[M_W-1:LO_W]) * (2*HI_W)'(my7[M_W-1:LO_W]);
      hl_x8 <= (HI_W+LO_W)'(mx7[M_W-1:LO_W]) * (HI_W+LO_W)'(mx7[LO_W-1:0]);
      hl_y8 <= (HI_W+LO_W)'(my7[M_W-1:LO_W]) * (HI_W+LO_W)'(my7[LO_W-1:0]);
      ll_x8 <= (2*LO_W)'(mx7[LO_W-1:0]) * (2*LO_W)'(mx7[LO_W-1:0]);
      ll_y8 <= (2*LO_W)'(my7[LO_W-1:0]) * (2*LO_W)'(my7[LO_W-1:0]);
    end
  end

  // Stage 9: combine the partial products into the two squares.
  logic             v9, ovl9, hit9, sx9, sy9, n2z9;
  logic [TFB-1:0]   teff9;
  logic [SQ_W-1:0]  sq_x9, sq_y9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovl9  <= ovl8;
      hit9  <= hit8;
      teff9 <= teff8;
      sx9   <= sx8;
      sy9   <= sy8;
      n2z9  <= n2z8;
      sq_x9 <= (SQ_W'(hh_x8) << (2 * LO_W)) + (SQ_W'(hl_x8) << (LO_W + 1)) + SQ_W'(ll_x8);
      sq_y9 <= (SQ_W'(hh_y8) << (2 * LO_W)) + (SQ_W'(hl_y8) << (LO_W + 1)) + SQ_W'(ll_y8);
    end
  end

  // Stage 10: squared length of the impact vector.
  logic             v10, ovl10, hit10, sx10, sy10, n2z10;
  logic [TFB-1:0]   teff10;
  logic [SQ_W-1:0]  sq_x10, sq_y10;
  logic [N2_W-1:0]  n2_10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovl10  <= ovl9;
      hit10  <= hit9;
      teff10 <= teff9;
      sx10   <= sx9;
      sy10   <= sy9;
      n2z10  <= n2z9;
      sq_x10 <= sq_x9;
      sq_y10 <= sq_y9;
      n2_10  <= N2_W'(sq_x9) + N2_W'(sq_y9);
    end
  end

  // Each component is the largest m with m^2 |n|^2 <= 2^28 n_c^2, found by
  // its own search pipeline while the side-band item travels alongside.
  nrm_side_t       sd2_in;
  nrm_side_t       sd2 [NS];
  logic [NS-1:0]   mag_x, mag_y;

  always_comb begin
    sd2_in.valid = v10;
    sd2_in.ovl   = ovl10;
    sd2_in.hit   = hit10;
    sd2_in.teff  = teff10;
    sd2_in.sx    = sx10;
    sd2_in.sy    = sy10;
    sd2_in.n2z   = n2z10;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        sd2[i].valid <= 1'b0;
      end
    end else if (en) begin
      sd2[0] <= sd2_in;
      for (int i = 1; i < NS; i++) begin
        sd2[i] <= sd2[i-1];
      end
    end
  end

  scc_norm u_norm_x (
    .clk (clk),
    .en  (en),
    .n2  (n2_10),
    .sq  (sq_x10),
    .m   (mag_x)
  );

  scc_norm u_norm_y (
    .clk (clk),
    .en  (en),
    .n2  (n2_10),
    .sq  (sq_y10),
    .m   (mag_y)
  );

  // Output register: fields other than the overlap flag are zero without a hit,
  // and the normal is also zero when the impact point sits on the other centre.
  logic                   nrm_ok;
  logic [NRM_W-1:0]       nx_u, ny_u;

  assign nrm_ok = sd2[NS-1].hit && !sd2[NS-1].n2z;
  assign nx_u   = NRM_W'(mag_x);
  assign ny_u   = NRM_W'(mag_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sd2[NS-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      overlapping <= sd2[NS-1].ovl;
      hit         <= sd2[NS-1].hit;
      impact_time <= sd2[NS-1].hit ? sd2[NS-1].teff : '0;
      normal_x    <= !nrm_ok ? '0 : (sd2[NS-1].sx ? (-nx_u) : nx_u);
      normal_y    <= !nrm_ok ? '0 : (sd2[NS-1].sy ? (-ny_u) : ny_u);
    end
  end

endmodule
